// ===== rtl/stff_pkg.sv =====
package stff_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int TYPE_W  = 2;
    localparam int INDEX_W = 6;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [TYPE_W-1:0] {
        REQ_PUT    = 2'd0,
        REQ_SET    = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETTLE,
        ST_TRIM
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic trim;
    } t_cmd;

    typedef struct packed {
        logic clear_top;
    } t_sts;

endpackage

// ===== rtl/stff_ram.sv =====
module stff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stff_ctrl.sv =====
module stff_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  stff_pkg::t_sts i_sts,
    output stff_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    import stff_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // clearing the top slot needs the bitmap search on the new map
                n_state = i_sts.clear_top ? ST_SETTLE : ST_IDLE;
            end
            ST_SETTLE: n_state = ST_TRIM;
            ST_TRIM:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_EXEC:   o_cmd.exec = 1'b1;
            ST_SETTLE: o_cmd      = '0;
            ST_TRIM:   o_cmd.trim = 1'b1;
            default:   o_busy     = 1'b1;
        endcase
    end

endmodule

// ===== rtl/stff_dp.sv =====
module stff_dp #(
    parameter int SLOTS      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  stff_pkg::t_cmd                  i_cmd,
    output stff_pkg::t_sts                  o_sts,
    input  logic [stff_pkg::TYPE_W-1:0]     i_req_type,
    input  logic [stff_pkg::INDEX_W-1:0]    i_slot_index,
    input  logic [stff_pkg::WORD_W-1:0]     i_entry_value,
    output logic                            o_valid,
    output logic [stff_pkg::INDEX_W-1:0]    o_result_index,
    output logic [stff_pkg::WORD_W-1:0]     o_read_value,
    output logic                            o_status,
    output logic [stff_pkg::COUNT_W-1:0]    o_high_water,
    output logic [stff_pkg::COUNT_W-1:0]    o_used_count
);

    import stff_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int MW = $clog2(SLOTS + 1);

    // request held for the whole operation
    t_req                  r_kind;
    logic [INDEX_W-1:0]    r_idx;
    logic [VALUE_BITS-1:0] r_val;

    // table state
    logic [SLOTS-1:0] r_occ;
    logic [SLOTS-1:0] n_occ;
    logic [MW-1:0]    r_mark;
    logic [MW-1:0]    n_mark;
    logic [MW-1:0]    r_used;
    logic [MW-1:0]    n_used;

    // registered bitmap searches
    logic [IW-1:0] r_free_idx;
    logic          r_full;
    logic [IW-1:0] r_top_idx;
    logic          r_any;

    // result word
    logic                r_o_valid;
    logic [INDEX_W-1:0]  r_o_index;
    logic [WORD_W-1:0]   r_o_value;
    logic                r_o_status;
    logic [COUNT_W-1:0]  r_o_mark;
    logic [COUNT_W-1:0]  r_o_used;

    logic [SLOTS-1:0] free_hot;
    logic [SLOTS-1:0] occ_rev;
    logic [SLOTS-1:0] top_hot;
    logic [IW-1:0]    free_enc;
    logic [IW-1:0]    top_enc;

    logic                  in_range;
    logic [IW-1:0]         tidx;
    logic                  wr_en;
    logic [IW-1:0]         wr_idx;
    logic [VALUE_BITS-1:0] ram_q;
    logic                  emit;
    logic [INDEX_W-1:0]    res_index;
    logic [WORD_W-1:0]     res_value;
    logic                  res_status;
    logic                  clear_top;

    stff_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx),
        .i_wdata (r_val),
        .i_raddr (IW'(i_slot_index)),
        .o_rdata (ram_q)
    );

    // lowest empty slot: slots at or above the mark are always empty
    assign free_hot = ~r_occ & (r_occ + SLOTS'(1));

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            occ_rev[j] = r_occ[SLOTS-1-j];
        end
    end

    assign top_hot = occ_rev & (~occ_rev + SLOTS'(1));

    always_comb begin
        free_enc = '0;
        top_enc  = '0;
        for (int j = 0; j < SLOTS; j++) begin
            if (free_hot[j]) begin
                free_enc = free_enc | IW'(j);
            end
            if (top_hot[j]) begin
                top_enc = top_enc | IW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= free_enc;
        r_full     <= &r_occ;
        r_top_idx  <= IW'(SLOTS - 1) - top_enc;
        r_any      <= |r_occ;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_req'(i_req_type);
            r_idx  <= i_slot_index;
            r_val  <= VALUE_BITS'(i_entry_value);
        end
    end

    assign in_range = 32'(r_idx) < 32'(SLOTS);
    assign tidx     = IW'(r_idx);

    always_comb begin
        n_occ      = r_occ;
        n_mark     = r_mark;
        n_used     = r_used;
        wr_en      = 1'b0;
        wr_idx     = tidx;
        res_index  = r_idx;
        res_value  = '0;
        res_status = 1'b0;
        clear_top  = 1'b0;
        emit       = 1'b0;

        if (i_cmd.exec) begin
            emit = 1'b1;
            case (r_kind)
                REQ_PUT: begin
                    if (r_full) begin
                        res_status = 1'b1;
                        res_index  = '0;
                    end else begin
                        wr_en     = 1'b1;
                        wr_idx    = r_free_idx;
                        res_index = INDEX_W'(r_free_idx);
                    end
                end
                REQ_SET: begin
                    if (in_range) begin
                        wr_en = 1'b1;
                    end else begin
                        res_status = 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    if (in_range) begin
                        n_occ[tidx] = 1'b0;
                        if (r_occ[tidx]) begin
                            n_used = r_used - MW'(1);
                        end
                        if (MW'(tidx) + MW'(1) == r_mark) begin
                            clear_top = 1'b1;
                            emit      = 1'b0;
                        end
                    end
                end
                REQ_LOOKUP: begin
                    if (in_range && r_occ[tidx] && (MW'(tidx) < r_mark)) begin
                        res_value = WORD_W'(ram_q);
                    end
                end
                default: res_status = 1'b0;
            endcase

            if (wr_en) begin
                n_occ[wr_idx] = (r_val != '0);
                if (r_occ[wr_idx] && (r_val == '0)) begin
                    n_used = r_used - MW'(1);
                end else if (!r_occ[wr_idx] && (r_val != '0)) begin
                    n_used = r_used + MW'(1);
                end
                if (r_mark <= MW'(wr_idx)) begin
                    n_mark = MW'(wr_idx) + MW'(1);
                end
            end
        end

        if (i_cmd.trim) begin
            // drop the mark to one past the highest occupied slot, or to zero if none is occupied
            emit   = 1'b1;
            n_mark = r_any ? MW'(r_top_idx) + MW'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_mark    <= '0;
            r_used    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_occ     <= n_occ;
            r_mark    <= n_mark;
            r_used    <= n_used;
            r_o_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_index  <= res_index;
            r_o_value  <= res_value;
            r_o_status <= res_status;
            r_o_mark   <= COUNT_W'(n_mark);
            r_o_used   <= COUNT_W'(n_used);
        end
    end

    assign o_sts.clear_top = clear_top;
    assign o_valid         = r_o_valid;
    assign o_result_index  = r_o_index;
    assign o_read_value    = r_o_value;
    assign o_status        = r_o_status;
    assign o_high_water    = r_o_mark;
    assign o_used_count    = r_o_used;

endmodule

// ===== rtl/slot_table_first_free.sv =====
// Steps: the accepting edge loads the request; EXEC performs it and registers the
// result word. A top-slot clear instead goes through SETTLE, so the registered
// occupancy search sees the new map, then TRIM, which lowers the mark and emits.
// A new request is taken only in IDLE; the read of the value RAM is registered.
// Reset: synchronous, active low; empties the table, zeroes mark and count.
// The receiver cannot stall: each result shows for exactly one cycle.
module slot_table_first_free #(
    parameter int SLOTS      = stff_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = stff_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [stff_pkg::TYPE_W-1:0]     i_req_type,
    input  logic [stff_pkg::INDEX_W-1:0]    i_slot_index,
    input  logic [stff_pkg::WORD_W-1:0]     i_entry_value,
    output logic                            o_valid,
    output logic [stff_pkg::INDEX_W-1:0]    o_result_index,
    output logic [stff_pkg::WORD_W-1:0]     o_read_value,
    output logic                            o_status,
    output logic [stff_pkg::COUNT_W-1:0]    o_high_water,
    output logic [stff_pkg::COUNT_W-1:0]    o_used_count
);

    import stff_pkg::*;

    t_cmd cmd;
    t_sts sts;

    stff_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    stff_dp #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_req_type),
        .i_slot_index   (i_slot_index),
        .i_entry_value  (i_entry_value),
        .o_valid        (o_valid),
        .o_result_index (o_result_index),
        .o_read_value   (o_read_value),
        .o_status       (o_status),
        .o_high_water   (o_high_water),
        .o_used_count   (o_used_count)
    );

    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a request in progress");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_trim_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.clear_top |=> (busy && !o_valid))
        else $error("top-slot clear reported before the mark was trimmed");

endmodule
